// ===== rtl/fasr_pkg.sv =====
// Package for the fraction add/subtract/reduce block: payload types and constants.
// Used by every module under rtl; depends on nothing.
`default_nettype none
package fasr_pkg;
  localparam int OperandWidth = 32;
  localparam int QueueDepth = 2;

  typedef struct packed {
    logic        op;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic [63:0] res_num;
    logic [63:0] res_den;
    logic        zero_gcd_error;
  } out_item_t;

  // Work handed from the front part to the back part.
  typedef struct packed {
    logic [63:0] x;
    logic [63:0] y;
  } work_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_GCD, ST_DIVX, ST_DIVY, ST_OUT
  } back_state_t;

  typedef enum logic [1:0] {
    FR_IDLE, FR_MUL, FR_SUM
  } front_state_t;
endpackage
`default_nettype wire

// ===== rtl/fasr_front.sv =====
// Front part: sign-extends operands, forms cross products, then their sum or difference.
// Depends on fasr_pkg.
`default_nettype none
module fasr_front #(
  parameter int OPERAND_WIDTH = fasr_pkg::OperandWidth
) (
  input  wire                 clk,
  input  wire                 rst,
  input  fasr_pkg::in_item_t  in_item,
  input  wire                 in_valid,
  output logic                in_ready,
  output fasr_pkg::work_t     work,
  output logic                work_valid,
  input  wire                 work_ready
);
  fasr_pkg::front_state_t state, state_next;
  logic               sub;
  logic signed [31:0] an, ad, bn, bd;
  logic signed [63:0] p1, p2, py;

  function automatic logic signed [31:0] sext(input logic [31:0] v);
    logic signed [OPERAND_WIDTH-1:0] t;
    t = v[OPERAND_WIDTH-1:0];
    return 32'(t);
  endfunction

  always_comb begin
    state_next = state;
    unique case (state)
      fasr_pkg::FR_IDLE: if (in_valid) state_next = fasr_pkg::FR_MUL;
      fasr_pkg::FR_MUL:  state_next = fasr_pkg::FR_SUM;
      fasr_pkg::FR_SUM:  if (work_ready) state_next = fasr_pkg::FR_IDLE;
      default:           state_next = fasr_pkg::FR_IDLE;
    endcase
  end

  // The sum works on registered products, so the queue sees one adder after the flops.
  always_comb begin
    in_ready   = (state == fasr_pkg::FR_IDLE);
    work_valid = (state == fasr_pkg::FR_SUM);
    work.x     = sub ? p1 - p2 : p1 + p2;
    work.y     = py;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fasr_pkg::FR_IDLE;
    end else begin
      state <= state_next;
    end
    if (state == fasr_pkg::FR_IDLE && in_valid) begin
      sub <= in_item.op;
      an  <= sext(in_item.a_num);
      ad  <= sext(in_item.a_den);
      bn  <= sext(in_item.b_num);
      bd  <= sext(in_item.b_den);
    end
    if (state == fasr_pkg::FR_MUL) begin
      // Operands are sign-extended 32-bit values, so each product is a 32x32 signed multiply.
      p1 <= 64'(an) * 64'(bd);
      p2 <= 64'(bn) * 64'(ad);
      py <= 64'(ad) * 64'(bd);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/fasr_queue.sv =====
// Short queue between front and back parts.
// Depends on fasr_pkg.
`default_nettype none
module fasr_queue #(
  parameter int DEPTH = fasr_pkg::QueueDepth
) (
  input  wire              clk,
  input  wire              rst,
  input  fasr_pkg::work_t  wr_data,
  input  wire              wr_valid,
  output logic             wr_ready,
  output fasr_pkg::work_t  rd_data,
  output logic             rd_valid,
  input  wire              rd_ready
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  fasr_pkg::work_t   mem [DEPTH];
  logic [AW-1:0]     wp, rp;
  logic [AW:0]       count;
  logic              do_wr, do_rd;

  assign wr_ready = (count != (AW+1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rp];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (do_wr) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (do_rd) rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      count <= count + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
    if (do_wr) mem[wp] <= wr_data;
  end
endmodule
`default_nettype wire

// ===== rtl/fasr_back.sv =====
// Back part: gcd by Euclid and, unless the gcd is zero, two divisions on one shared restoring divider.
// Depends on fasr_pkg.
`default_nettype none
module fasr_back (
  input  wire                 clk,
  input  wire                 rst,
  input  fasr_pkg::work_t     work,
  input  wire                 work_valid,
  output logic                work_ready,
  output fasr_pkg::out_item_t res,
  output logic                res_valid,
  input  wire                 res_ready
);
  fasr_pkg::back_state_t state, state_next;
  logic [63:0] x, y, p, q, g;
  // Shared divider: dividend shifts into remainder, one bit per cycle.
  logic [63:0] dvd, dvs, rem;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] trial;
  logic        div_done;

  assign trial    = {rem, dvd[63]} - {1'b0, dvs};
  assign div_done = busy && (cnt == 7'd63);

  always_comb begin
    state_next = state;
    unique case (state)
      fasr_pkg::ST_IDLE: if (work_valid) state_next = fasr_pkg::ST_GCD;
      fasr_pkg::ST_GCD:
        if (!busy && p == '0) state_next = (q == '0) ? fasr_pkg::ST_OUT : fasr_pkg::ST_DIVX;
      fasr_pkg::ST_DIVX: if (div_done) state_next = fasr_pkg::ST_DIVY;
      fasr_pkg::ST_DIVY: if (div_done) state_next = fasr_pkg::ST_OUT;
      fasr_pkg::ST_OUT:  if (res_ready) state_next = fasr_pkg::ST_IDLE;
      default:           state_next = fasr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    work_ready = (state == fasr_pkg::ST_IDLE);
    res_valid  = (state == fasr_pkg::ST_OUT);
  end

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? 64'(0) - v : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fasr_pkg::ST_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      if (busy) begin
        busy <= !div_done;
      end else if ((state == fasr_pkg::ST_GCD && p != '0) ||
                   (state == fasr_pkg::ST_DIVX) || (state == fasr_pkg::ST_DIVY)) begin
        busy <= 1'b1;
      end
    end

    if (state == fasr_pkg::ST_IDLE && work_valid) begin
      x <= work.x;
      y <= work.y;
      p <= mag(work.x);
      q <= mag(work.y);
    end

    if (!busy) begin
      cnt <= '0;
      rem <= '0;
      priority case (state)
        fasr_pkg::ST_GCD: begin dvd <= q; dvs <= p; end
        fasr_pkg::ST_DIVX: begin dvd <= mag(x); dvs <= g; end
        default: begin dvd <= mag(y); dvs <= g; end
      endcase
      if (state == fasr_pkg::ST_GCD && p == '0) begin
        g <= q;
        res.res_num <= '0;
        res.res_den <= '0;
        res.zero_gcd_error <= (q == '0);
      end
    end else begin
      cnt <= cnt + 7'd1;
      dvd <= {dvd[62:0], !trial[64]};
      rem <= trial[64] ? {rem[62:0], dvd[63]} : trial[63:0];
      if (div_done) begin
        priority case (state)
          fasr_pkg::ST_GCD: begin
            q <= p;
            p <= trial[64] ? {rem[62:0], dvd[63]} : trial[63:0];
          end
          fasr_pkg::ST_DIVX: res.res_num <= x[63] ? 64'(0) - {dvd[62:0], !trial[64]}
                                                  : {dvd[62:0], !trial[64]};
          default: res.res_den <= y[63] ? 64'(0) - {dvd[62:0], !trial[64]}
                                        : {dvd[62:0], !trial[64]};
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/fraction_add_subtract_reduce.sv =====
// Top level: fraction add/subtract with gcd reduction.
// Depends on fasr_pkg, fasr_front, fasr_queue, fasr_back.
//
//  channel  | handshake   | payload
//  input    | push, full  | in_item  (fasr_pkg::in_item_t)
//  result   | pop, empty  | out_item (fasr_pkg::out_item_t)
//
// The front handles one item at a time and takes no new one until it has handed
// the last one on; the back runs Euclid with a bit-serial divider (one load, then
// shifts) for each modulo step, then two divisions on the same shared divider.
// Synchronous reset rst clears all control state; no clearing pass is needed.
// A stalled result holds and the front and queue keep accepting items meanwhile until the queue fills.
`default_nettype none
module fraction_add_subtract_reduce #(
  parameter int OPERAND_WIDTH = fasr_pkg::OperandWidth
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  output logic                full,
  input  fasr_pkg::in_item_t  in_item,
  input  wire                 pop,
  output logic                empty,
  output fasr_pkg::out_item_t out_item
);
  fasr_pkg::work_t fw, bw;
  logic fv, fr, bv, br, in_ready, res_valid;

  fasr_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk, .rst, .in_item, .in_valid(push), .in_ready,
    .work(fw), .work_valid(fv), .work_ready(fr));
  fasr_queue u_queue (
    .clk, .rst, .wr_data(fw), .wr_valid(fv), .wr_ready(fr),
    .rd_data(bw), .rd_valid(bv), .rd_ready(br));
  fasr_back u_back (
    .clk, .rst, .work(bw), .work_valid(bv), .work_ready(br),
    .res(out_item), .res_valid, .res_ready(pop));

  assign full  = !in_ready;
  assign empty = !res_valid;

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.zero_gcd_error) |-> (out_item.res_num == '0 && out_item.res_den == '0))
    else $error("error result carries nonzero fraction");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty && $stable(out_item))
    else $error("result changed while waiting");
endmodule
`default_nettype wire
